FILE: rtl/matrix3_inverse_unit_assert.svh
// Assertion macros for the matrix inverse block.
// Used by the top level only; depends on its aclk and aresetn ports.
`ifndef MATRIX3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_ASSERT_SVH

`define MI3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("matrix3 inverse: same-cycle check failed");

`define MI3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("matrix3 inverse: next-cycle check failed");

`endif

FILE: rtl/mi3_pkg.sv
// Shared widths, types and cofactor index tables for the matrix inverse block.
// No dependencies; imported by every module of the block.
package mi3_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int PW        = 2 * DW;
    localparam int CW        = PW + 1;
    localparam int TW        = CW + DW;
    localparam int DETW      = TW + 2;
    localparam int ADW       = DETW - 1;
    localparam int NW        = CW + 2 * FB;
    localparam int SHW       = ADW + DW;
    localparam int THW       = DW - 1;
    localparam int FRONT_STG = 5;
    localparam int LANE_STG  = DW + 1;
    localparam int PREP_IDX  = FRONT_STG;
    localparam int LANE_BASE = FRONT_STG + 1;
    localparam int NSTG      = FRONT_STG + LANE_STG + 2;

    localparam logic [DW-1:0] ONE_VAL = DW'(1) << FB;

    typedef logic signed [DW-1:0]   elem_t;
    typedef logic signed [CW-1:0]   cof_t;
    typedef logic signed [DETW-1:0] det_t;

    localparam int COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

FILE: rtl/mi3_front.sv
// Cofactor and determinant pipeline: five stages from the matrix to the exact
// adjugate and determinant. Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; (
    input  logic                 aclk,
    input  logic [FRONT_STG-1:0] en,
    input  elem_t                mat [9],
    output cof_t                 cof [9],
    output det_t                 det
);

    logic signed [PW-1:0] pa_reg [9];
    logic signed [PW-1:0] pb_reg [9];
    elem_t                mr0_reg [3];
    elem_t                mr1_reg [3];
    cof_t                 cof1_reg [9];
    cof_t                 cof2_reg [9];
    cof_t                 cof3_reg [9];
    cof_t                 cof4_reg [9];
    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];
    logic signed [TW-1:0] term_reg [3];
    det_t                 det_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 9; i++) begin
                pa_reg[i] <= mat[COF_A[i]] * mat[COF_B[i]];
                pb_reg[i] <= mat[COF_C[i]] * mat[COF_D[i]];
            end
            for (int j = 0; j < 3; j++) begin
                mr0_reg[j] <= mat[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 9; i++) begin
                cof1_reg[i] <= $signed({pa_reg[i][PW-1], pa_reg[i]})
                             - $signed({pb_reg[i][PW-1], pb_reg[i]});
            end
            mr1_reg <= mr0_reg;
        end
    end

    logic signed [DW:0] ulo [3];
    logic signed [DW:0] shi [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ulo[j] = $signed({1'b0, cof1_reg[3 * j][DW-1:0]});
            shi[j] = $signed(cof1_reg[3 * j][CW-1:DW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int j = 0; j < 3; j++) begin
                lo_reg[j] <= mr1_reg[j] * ulo[j];
                hi_reg[j] <= mr1_reg[j] * shi[j];
            end
            cof2_reg <= cof1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                term_reg[j] <= $signed({hi_reg[j], {DW{1'b0}}})
                             + $signed({{DW{lo_reg[j][CW-1]}}, lo_reg[j]});
            end
            cof3_reg <= cof2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            det_reg  <= $signed({{2{term_reg[0][TW-1]}}, term_reg[0]})
                      + $signed({{2{term_reg[1][TW-1]}}, term_reg[1]})
                      + $signed({{2{term_reg[2][TW-1]}}, term_reg[2]});
            cof4_reg <= cof3_reg;
        end
    end

    assign cof = cof4_reg;
    assign det = det_reg;

endmodule

FILE: rtl/mi3_lane.sv
// One output lane: sign handling, a restoring divider with one quotient bit per
// stage, and saturation to the element width. Depends on mi3_pkg.
module mi3_lane import mi3_pkg::*; (
    input  logic                aclk,
    input  logic [LANE_STG-1:0] en,
    input  cof_t                adj,
    input  logic [ADW-1:0]      adet,
    input  logic                det_neg,
    output logic [DW-1:0]       res
);

    logic [NW-1:0]  rem_reg [DW];
    logic [ADW-1:0] den_reg [DW];
    logic [DW-1:0]  q_reg   [1:DW];
    logic           neg_reg [DW+1];
    logic           sat_reg [DW+1];

    logic           aneg;
    logic [CW-1:0]  aabs;
    logic [NW-1:0]  num;

    always_comb begin
        aneg = adj[CW-1];
        aabs = aneg ? CW'(-adj) : CW'(adj);
        num  = {aabs, {(2 * FB){1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= num;
            den_reg[0] <= adet;
            neg_reg[0] <= aneg ^ det_neg;
            sat_reg[0] <= SHW'(num) >= {adet, {DW{1'b0}}};
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [SHW-1:0] sh;
        logic           ge;
        logic [DW-1:0]  qn;

        always_comb begin
            sh = SHW'(den_reg[k-1]) << (DW - k);
            ge = SHW'(rem_reg[k-1]) >= sh;
            qn = '0;
            if (k > 1) begin
                qn = q_reg[(k > 1) ? k - 1 : 1];
            end
            qn[DW - k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                q_reg[k]   <= qn;
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        if (k < DW) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - sh[NW-1:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    logic [DW-1:0] lim;
    logic [DW-1:0] mag;

    always_comb begin
        lim = neg_reg[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        mag = (sat_reg[DW] || (q_reg[DW] > lim)) ? lim : q_reg[DW];
        res = neg_reg[DW] ? DW'(-mag) : mag;
    end

endmodule

FILE: rtl/matrix3_inverse_unit.sv
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out, saturated.
// One item is accepted per clock cycle while the output is not stalled, and
// each result passes through five cofactor and determinant stages, one sign
// and threshold stage, 33 stages in each of nine parallel divider lanes (an
// overflow check, then one quotient bit per stage) and one output register.
// A determinant that is zero or whose magnitude is below the threshold gives
// the identity with status 1. Depends on mi3_pkg, mi3_front, mi3_lane and the
// assertion header.
`include "matrix3_inverse_unit_assert.svh"

module matrix3_inverse_unit import mi3_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [THW-1:0] cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [DW-1:0]  s_in_r1c1,
    input  logic [DW-1:0]  s_in_r1c2,
    input  logic [DW-1:0]  s_in_r1c3,
    input  logic [DW-1:0]  s_in_r2c1,
    input  logic [DW-1:0]  s_in_r2c2,
    input  logic [DW-1:0]  s_in_r2c3,
    input  logic [DW-1:0]  s_in_r3c1,
    input  logic [DW-1:0]  s_in_r3c2,
    input  logic [DW-1:0]  s_in_r3c3,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [DW-1:0]  m_out_r1c1,
    output logic [DW-1:0]  m_out_r1c2,
    output logic [DW-1:0]  m_out_r1c3,
    output logic [DW-1:0]  m_out_r2c1,
    output logic [DW-1:0]  m_out_r2c2,
    output logic [DW-1:0]  m_out_r2c3,
    output logic [DW-1:0]  m_out_r3c1,
    output logic [DW-1:0]  m_out_r3c2,
    output logic [DW-1:0]  m_out_r3c3,
    output logic           m_result_status
);

    logic [THW-1:0]  thr_reg;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THW'(1);
            vld_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            vld_reg <= vld_next;
        end
    end

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end
    assign en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            vld_next[k] = vld_reg[k];
            if (en[k]) begin
                vld_next[k] = (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTG-1];

    elem_t mat [9];

    always_comb begin
        mat[0] = s_in_r1c1;
        mat[1] = s_in_r1c2;
        mat[2] = s_in_r1c3;
        mat[3] = s_in_r2c1;
        mat[4] = s_in_r2c2;
        mat[5] = s_in_r2c3;
        mat[6] = s_in_r3c1;
        mat[7] = s_in_r3c2;
        mat[8] = s_in_r3c3;
    end

    cof_t cof [9];
    det_t det;

    mi3_front u_front (
        .aclk (aclk),
        .en   (en[FRONT_STG-1:0]),
        .mat  (mat),
        .cof  (cof),
        .det  (det)
    );

    cof_t           adj_reg [9];
    logic [ADW-1:0] adet_reg;
    logic           dneg_reg;
    logic           sing_reg;
    logic [DETW-1:0] dabs;

    always_comb begin
        dabs = det[DETW-1] ? DETW'(-det) : DETW'(det);
    end

    always_ff @(posedge aclk) begin
        if (en[PREP_IDX]) begin
            adj_reg  <= cof;
            adet_reg <= dabs[ADW-1:0];
            dneg_reg <= det[DETW-1];
            sing_reg <= (det == '0)
                     || (dabs[ADW-1:0] < ADW'({thr_reg, {(2 * FB){1'b0}}}));
        end
    end

    logic [DW-1:0] lane_res [9];

    for (genvar i = 0; i < 9; i++) begin : g_lane
        mi3_lane u_lane (
            .aclk    (aclk),
            .en      (en[LANE_BASE +: LANE_STG]),
            .adj     (adj_reg[i]),
            .adet    (adet_reg),
            .det_neg (dneg_reg),
            .res     (lane_res[i])
        );
    end

    logic sing_pipe_reg [LANE_STG];

    for (genvar k = 0; k < LANE_STG; k++) begin : g_sing
        always_ff @(posedge aclk) begin
            if (en[LANE_BASE + k]) begin
                sing_pipe_reg[k] <= (k == 0) ? sing_reg : sing_pipe_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    logic [DW-1:0] out_reg [9];
    logic          status_reg;

    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            for (int i = 0; i < 9; i++) begin
                if (sing_pipe_reg[LANE_STG-1]) begin
                    out_reg[i] <= (i % 4 == 0) ? ONE_VAL : '0;
                end else begin
                    out_reg[i] <= lane_res[i];
                end
            end
            status_reg <= sing_pipe_reg[LANE_STG-1];
        end
    end

    assign m_out_r1c1      = out_reg[0];
    assign m_out_r1c2      = out_reg[1];
    assign m_out_r1c3      = out_reg[2];
    assign m_out_r2c1      = out_reg[3];
    assign m_out_r2c2      = out_reg[4];
    assign m_out_r2c3      = out_reg[5];
    assign m_out_r3c1      = out_reg[6];
    assign m_out_r3c2      = out_reg[7];
    assign m_out_r3c3      = out_reg[8];
    assign m_result_status = status_reg;

    `MI3_ASSERT_IMP(a_sing_diag, m_valid && m_result_status, m_out_r2c2 == ONE_VAL && m_out_r1c1 == ONE_VAL)
    `MI3_ASSERT_IMP(a_sing_off, m_valid && m_result_status, m_out_r1c2 == '0 && m_out_r3c1 == '0)
    `MI3_ASSERT_IMP(a_full_stall, !s_ready, m_valid && !m_ready && vld_reg == '1)
    `MI3_ASSERT_NXT(a_take_item, s_valid && s_ready, vld_reg[0])

endmodule
